// File: sv/ssr_pkg.sv
`default_nettype none

package ssr_pkg;

  localparam int WIN_DEPTH       = 8;
  localparam int PATTERN_MAX     = 8;
  localparam int REPLACEMENT_MAX = 8;

  localparam int PLEN_CAP = (PATTERN_MAX < WIN_DEPTH) ? PATTERN_MAX : WIN_DEPTH;
  localparam int RLEN_CAP = (REPLACEMENT_MAX < WIN_DEPTH) ? REPLACEMENT_MAX : WIN_DEPTH;

  localparam int IDX_W  = $clog2(WIN_DEPTH);
  localparam int FILL_W = $clog2(WIN_DEPTH + 1);

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int LIMIT_W    = 17;
  localparam int DONE_W     = 16;
  localparam int LEN_W      = 4;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    REG_PATTERN_BYTES      = 3'd0,
    REG_PATTERN_LENGTH     = 3'd1,
    REG_REPLACEMENT_BYTES  = 3'd2,
    REG_REPLACEMENT_LENGTH = 3'd3,
    REG_REPLACE_LIMIT      = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: sv/ssr_in_if.sv
`default_nettype none

interface ssr_in_if;
  import ssr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  is_final;

  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

`default_nettype wire

// File: sv/ssr_out_if.sv
`default_nettype none

interface ssr_out_if;
  import ssr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  byte_valid;
  logic  last;

  modport source (output valid, output out_byte, output byte_valid, output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last, output ready);
endinterface

`default_nettype wire

// File: sv/stream_substring_replace_top.sv
// Streaming search and replace over a byte string.
// in_ch carries one byte per transfer; is_final marks the last byte of a string.
// out_ch carries the rewritten string one byte per transfer; last marks its end,
// and a final byte that leaves nothing to emit ends the string with one transfer
// with byte_valid 0.
// The APB port sets pattern, pattern length, replacement, replacement length and
// the replacement limit (negative means unlimited); registers sit at 8-byte steps.
// Up to pattern-length input bytes are held back in a window before they appear.
// Each accepted byte yields a batch of 0 to 8 results, computed in the accept
// cycle and loaded into an output batch register; the first result is visible
// on out_ch the next cycle.
// Throughput: one input byte per cycle while each byte yields at most one
// result and the receiver is ready; a byte that yields several results holds
// the output register until all have left, and the next byte is taken then.
// When the receiver stalls, the batch holds and input is held off while any
// result of the batch waits.
// Reset clears the window, the replacement count and the output batch, and
// returns the registers to pattern length 1, empty replacement, no limit.
`default_nettype none

module stream_substring_replace_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ssr_in_if.sink                             in_ch,
  ssr_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ssr_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [ssr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [ssr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready
);
  import ssr_pkg::*;

  // configuration registers
  logic [63:0]          pat_bytes_r;
  logic [LEN_W-1:0]     pat_len_r;
  logic [63:0]          rep_bytes_r;
  logic [LEN_W-1:0]     rep_len_r;
  logic [LIMIT_W-1:0]   limit_r;

  // stream state
  byte_t                win_r [WIN_DEPTH];
  byte_t                win_nxt [WIN_DEPTH];
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [DONE_W-1:0]    done_r, done_nxt;

  // output batch
  byte_t                bat_r [WIN_DEPTH];
  logic [FILL_W-1:0]    bat_cnt_r;
  logic                 bat_bval_r;
  logic                 bat_last_r;

  cfg_reg_t             wr_idx;
  logic                 cfg_wr;

  logic                 in_xfer, out_xfer;

  // step logic
  byte_t                win_a [WIN_DEPTH];
  byte_t                pat_b [WIN_DEPTH];
  byte_t                rep_b [WIN_DEPTH];
  logic [FILL_W-1:0]    fill_a;
  logic [FILL_W-1:0]    plen, rlen;
  logic [FILL_W-1:0]    shamt;
  logic [FILL_W-1:0]    n_res;
  logic                 unlimited, allowed, matched, hit;
  logic [DONE_W-1:0]    limit;
  logic                 over, at_len;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign wr_idx = cfg_reg_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= LEN_W'(1);
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
      limit_r     <= '1;
    end else if (cfg_wr) begin
      case (wr_idx)
        REG_PATTERN_BYTES:      pat_bytes_r <= pwdata;
        REG_PATTERN_LENGTH:     pat_len_r   <= pwdata[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  rep_bytes_r <= pwdata;
        REG_REPLACEMENT_LENGTH: rep_len_r   <= pwdata[LEN_W-1:0];
        REG_REPLACE_LIMIT:      limit_r     <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_PATTERN_BYTES:      prdata = pat_bytes_r;
      REG_PATTERN_LENGTH:     prdata = CFG_DATA_W'(pat_len_r);
      REG_REPLACEMENT_BYTES:  prdata = rep_bytes_r;
      REG_REPLACEMENT_LENGTH: prdata = CFG_DATA_W'(rep_len_r);
      REG_REPLACE_LIMIT:      prdata = CFG_DATA_W'(limit_r);
      default:                prdata = '0;
    endcase
  end

  // effective lengths and limit
  always_comb begin
    plen = pat_len_r;
    if (plen == '0) plen = FILL_W'(1);
    if (plen > FILL_W'(PLEN_CAP)) plen = FILL_W'(PLEN_CAP);
    rlen = rep_len_r;
    if (rlen > FILL_W'(RLEN_CAP)) rlen = FILL_W'(RLEN_CAP);
    unlimited = limit_r[LIMIT_W-1];
    limit     = unlimited ? '1 : limit_r[DONE_W-1:0];
    allowed   = unlimited || (done_r < limit);
  end

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  assign in_ch.ready = (bat_cnt_r == '0) || (out_xfer && bat_cnt_r == FILL_W'(1));

  // append the incoming byte, compare, pick what leaves the window
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_a[i] = win_r[i];
      pat_b[i] = pat_bytes_r[8*i +: 8];
      rep_b[i] = rep_bytes_r[8*i +: 8];
    end
    fill_a = fill_r;
    if (fill_r < FILL_W'(WIN_DEPTH)) begin
      win_a[fill_r[IDX_W-1:0]] = in_ch.data_byte;
      fill_a = fill_r + FILL_W'(1);
    end

    matched = 1'b1;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (FILL_W'(i) < plen && win_a[i] != pat_b[i]) matched = 1'b0;
    end

    over   = fill_a > plen;
    at_len = fill_a == plen;
    hit    = at_len && allowed && matched;

    if (over)              shamt = FILL_W'(2);
    else if (at_len && !hit) shamt = FILL_W'(1);
    else                   shamt = '0;

    if (hit)               n_res = rlen;
    else if (in_ch.is_final) n_res = fill_a;
    else                   n_res = shamt;

    for (int i = 0; i < WIN_DEPTH; i++) win_nxt[i] = '0;
    if (shamt == FILL_W'(2)) begin
      for (int i = 0; i < WIN_DEPTH - 2; i++) win_nxt[i] = win_a[i + 2];
    end else if (shamt == FILL_W'(1)) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) win_nxt[i] = win_a[i + 1];
    end else begin
      for (int i = 0; i < WIN_DEPTH; i++) win_nxt[i] = win_a[i];
    end

    if (in_ch.is_final || hit) fill_nxt = '0;
    else                       fill_nxt = fill_a - shamt;

    done_nxt = done_r;
    if (in_ch.is_final)            done_nxt = '0;
    else if (hit && done_r < limit) done_nxt = done_r + DONE_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      done_r <= '0;
      for (int i = 0; i < WIN_DEPTH; i++) win_r[i] <= '0;
    end else if (in_xfer) begin
      fill_r <= fill_nxt;
      done_r <= done_nxt;
      for (int i = 0; i < WIN_DEPTH; i++) win_r[i] <= win_nxt[i];
    end
  end

  // output batch: load on accept, shift one byte per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bat_cnt_r  <= '0;
      bat_bval_r <= 1'b0;
      bat_last_r <= 1'b0;
    end else if (in_xfer) begin
      if (in_ch.is_final && n_res == '0) begin
        bat_cnt_r  <= FILL_W'(1);
        bat_bval_r <= 1'b0;
      end else begin
        bat_cnt_r  <= n_res;
        bat_bval_r <= 1'b1;
      end
      bat_last_r <= in_ch.is_final;
    end else if (out_xfer) begin
      bat_cnt_r <= bat_cnt_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        if (in_ch.is_final && n_res == '0) bat_r[i] <= '0;
        else if (hit)                     bat_r[i] <= rep_b[i];
        else                              bat_r[i] <= win_a[i];
      end
    end else if (out_xfer) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) bat_r[i] <= bat_r[i + 1];
      bat_r[WIN_DEPTH-1] <= '0;
    end
  end

  assign out_ch.valid      = bat_cnt_r != '0;
  assign out_ch.out_byte   = bat_r[0];
  assign out_ch.byte_valid = bat_bval_r;
  assign out_ch.last       = bat_last_r && (bat_cnt_r == FILL_W'(1));

  // window never reaches full depth between items
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < FILL_W'(WIN_DEPTH))
    else $error("window fill out of range");

  // end of string empties the window and restarts the count
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.is_final) |=> (fill_r == '0 && done_r == '0))
    else $error("state not cleared after final byte");

  // a batch never holds more results than the window depth
  a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bat_cnt_r <= FILL_W'(WIN_DEPTH))
    else $error("batch count out of range");

  // an empty end marker is always the last result
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.byte_valid) |-> out_ch.last)
    else $error("empty marker without last");

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ssr_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  bv;
    logic  last;
  } text_beat_t;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    idx;
    logic [63:0] value;
    byte_t       data;
    logic        fin;
    logic        typed;
    text_beat_t  want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  wire  [CFG_DATA_W-1:0] prdata;
  wire  pready;

  ssr_in_if  in_ch ();
  ssr_out_if out_ch ();

  stream_substring_replace_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register copies and window state of the rewrite predictor
  logic [63:0] pat_reg    = '0;
  logic [3:0]  plen_reg   = 4'd1;
  logic [63:0] subst_reg  = '0;
  logic [3:0]  slen_reg   = 4'd0;
  logic [16:0] cap_reg    = 17'h1FFFF;
  byte_t       win_q [WIN_DEPTH];
  int unsigned win_fill   = 0;
  logic [15:0] subst_count = '0;

  text_beat_t rewrite_out[$];
  text_beat_t expected_text[$];
  dir_row_t   dir_tab[$];

  int  n_err     = 0;
  int  n_items   = 0;
  int  n_results = 0;
  int  n_strings = 0;
  int  n_phases  = 0;
  bit  tx_eager  = 0;
  bit  rx_eager  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic dir_row_t row_w(cfg_reg_t idx, logic [63:0] v);
    dir_row_t r;
    r = '0;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = v;
    return r;
  endfunction

  function automatic dir_row_t row_b(byte_t d, logic fin, logic typed = 1'b0,
                                     text_beat_t want = '0);
    dir_row_t r;
    r = '0;
    r.kind  = ROW_BYTE;
    r.data  = d;
    r.fin   = fin;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function void emit_byte(byte_t b);
    text_beat_t t;
    t.data = b;
    t.bv   = 1'b1;
    t.last = 1'b0;
    if (rewrite_out.size() < WIN_DEPTH) rewrite_out.push_back(t);
  endfunction

  function void shift_window();
    if (win_fill == 0) return;
    emit_byte(win_q[0]);
    for (int i = 1; i < WIN_DEPTH; i++) win_q[i-1] = win_q[i];
    win_q[WIN_DEPTH-1] = '0;
    win_fill--;
  endfunction

  function void clear_window();
    for (int i = 0; i < WIN_DEPTH; i++) win_q[i] = '0;
    win_fill = 0;
  endfunction

  // Results caused by one input byte, left in rewrite_out
  function void rewrite_byte(byte_t b, logic fin);
    int unsigned plen;
    int unsigned slen;
    logic        no_cap;
    logic [15:0] cap;
    logic        hit;
    text_beat_t  empty_end;
    rewrite_out.delete();
    plen = plen_reg;
    if (plen < 1) plen = 1;
    if (plen > PLEN_CAP) plen = PLEN_CAP;
    slen = slen_reg;
    if (slen > RLEN_CAP) slen = RLEN_CAP;
    no_cap = cap_reg[16];
    cap = no_cap ? 16'hFFFF : cap_reg[15:0];
    if (win_fill < WIN_DEPTH) begin
      win_q[win_fill] = b;
      win_fill++;
    end
    if (win_fill > plen) begin
      // window left over from a longer pattern: drain two per step
      shift_window();
      shift_window();
    end else if (win_fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (win_q[i] != pat_reg[8*i +: 8]) hit = 1'b0;
      if ((no_cap || subst_count < cap) && hit) begin
        for (int i = 0; i < slen; i++) emit_byte(subst_reg[8*i +: 8]);
        clear_window();
        if (subst_count < cap) subst_count++;
      end else begin
        shift_window();
      end
    end
    if (fin) begin
      while (win_fill > 0) shift_window();
      if (rewrite_out.size() == 0) begin
        empty_end = '{8'h00, 1'b0, 1'b1};
        rewrite_out.push_back(empty_end);
      end else begin
        rewrite_out[rewrite_out.size()-1].last = 1'b1;
      end
      clear_window();
      subst_count = '0;
    end
  endfunction

  // Hold input off and let the output batch drain before touching registers
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_PATTERN_BYTES:      pat_reg   = v;
      REG_PATTERN_LENGTH:     plen_reg  = v[3:0];
      REG_REPLACEMENT_BYTES:  subst_reg = v;
      REG_REPLACEMENT_LENGTH: slen_reg  = v[3:0];
      REG_REPLACE_LIMIT:      cap_reg   = v[16:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(byte_t d, logic fin, logic typed, text_beat_t want);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.is_final  <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // transfer taken at this edge
    n_items++;
    if (fin) n_strings++;
    rewrite_byte(d, fin);
    if (typed) expected_text.push_back(want);
    else foreach (rewrite_out[i]) expected_text.push_back(rewrite_out[i]);
  endtask

  initial begin : result_sink
    int stall;
    text_beat_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_eager ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      n_results++;
      if (expected_text.size() == 0) begin
        $display("%0t: result with nothing expected: byte %h byte_valid %b last %b",
                 $time, out_ch.out_byte, out_ch.byte_valid, out_ch.last);
        n_err++;
      end else begin
        want = expected_text.pop_front();
        if (out_ch.out_byte !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data,
                   out_ch.out_byte);
          n_err++;
        end
        if (out_ch.byte_valid !== want.bv) begin
          $display("%0t: byte_valid expected %b actual %b", $time, want.bv,
                   out_ch.byte_valid);
          n_err++;
        end
        if (out_ch.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_ch.last);
          n_err++;
        end
      end
      if ($urandom_range(0, 29) == 0) rx_eager = !rx_eager;
    end
  end

  initial begin : stimulus
    int          rand_items;
    int          nstr;
    int          slen;
    int          plen_e;
    int          pre;
    bit          noisy;
    byte_t       alpha0;
    byte_t       alpha1;
    logic [63:0] pat;
    logic [63:0] subst;
    logic [3:0]  pl;
    logic [3:0]  sl;
    logic [16:0] cap;
    byte_t       text_q[$];

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.is_final  <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    clear_window();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_tab = '{
      // reset settings: one-byte pattern 00, empty replacement, no limit
      row_b(8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}),
      row_b(8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}),
      row_b(8'h00, 1'b0),
      row_b(8'h7E, 1'b1),
      // full-length replacement, limit of one per string
      row_w(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF),
      row_w(REG_PATTERN_LENGTH, 64'd2),
      row_w(REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF),
      row_w(REG_REPLACEMENT_LENGTH, 64'd8),
      row_w(REG_REPLACE_LIMIT, 64'd1),
      row_b(8'hFF, 1'b0),
      row_b(8'hFF, 1'b0),
      row_b(8'hFF, 1'b0),
      row_b(8'hFF, 1'b1),
      // zero pattern length acts as one, oversized replacement length, pass through
      row_w(REG_PATTERN_LENGTH, 64'd0),
      row_w(REG_REPLACEMENT_LENGTH, 64'd15),
      row_w(REG_REPLACE_LIMIT, 64'd0),
      row_b(8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}),
      row_w(REG_REPLACE_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF),
      row_b(8'hFF, 1'b0),
      row_b(8'h00, 1'b1),
      // oversized pattern length saturates at eight
      row_w(REG_PATTERN_BYTES, 64'h0102_0304_0506_0708),
      row_w(REG_PATTERN_LENGTH, 64'd15),
      row_w(REG_REPLACEMENT_LENGTH, 64'd3),
      row_b(8'h08, 1'b0),
      row_b(8'h07, 1'b0),
      row_b(8'h06, 1'b0),
      row_b(8'h05, 1'b0),
      row_b(8'h04, 1'b0),
      row_b(8'h03, 1'b0),
      row_b(8'h02, 1'b0),
      row_b(8'h01, 1'b1),
      // shrink the pattern while the window holds bytes
      row_w(REG_PATTERN_LENGTH, 64'd4),
      row_b(8'hAA, 1'b0),
      row_b(8'h55, 1'b0),
      row_b(8'h00, 1'b0),
      row_w(REG_PATTERN_LENGTH, 64'd1),
      row_b(8'h11, 1'b0),
      row_b(8'h22, 1'b1)
    };

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].value);
      end else begin
        send_byte(dir_tab[i].data, dir_tab[i].fin, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    rand_items = 0;
    while (rand_items < 250) begin
      alpha0 = byte_t'($urandom);
      alpha1 = byte_t'($urandom);
      for (int j = 0; j < 8; j++) pat[8*j +: 8] = $urandom_range(0, 1) ? alpha0 : alpha1;
      case ($urandom_range(0, 9))
        0: pat = '1;
        1: pat = '0;
        2: pat = {$urandom, $urandom};
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0:       pl = 4'd0;
        1:       pl = 4'($urandom_range(9, 15));
        2, 3:    pl = 4'($urandom_range(5, 8));
        default: pl = 4'($urandom_range(1, 4));
      endcase
      sl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(0, 8));
      subst = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0:       cap = 17'h1FFFF;
        1:       cap = 17'd0;
        2:       cap = 17'd1;
        3:       cap = 17'd2;
        4:       cap = 17'h0FFFF;
        5:       cap = {1'b1, 16'($urandom)};
        default: cap = 17'($urandom_range(0, 5));
      endcase
      plen_e = (pl == 0) ? 1 : (pl > 8) ? 8 : pl;

      wait_idle();
      write_reg(REG_PATTERN_BYTES, pat);
      write_reg(REG_PATTERN_LENGTH, {60'd0, pl});
      write_reg(REG_REPLACEMENT_BYTES, subst);
      write_reg(REG_REPLACEMENT_LENGTH, {60'd0, sl});
      write_reg(REG_REPLACE_LIMIT, {{47{cap[16]}}, cap});
      n_phases++;

      nstr = $urandom_range(1, 4);
      for (int s = 0; s < nstr; s++) begin
        text_q.delete();
        slen = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 14);
        noisy = ($urandom_range(0, 3) == 0);
        while (text_q.size() < slen) begin
          if (noisy) begin
            text_q.push_back(byte_t'($urandom));
          end else begin
            case ($urandom_range(0, 5))
              0, 1, 2: for (int j = 0; j < plen_e; j++) text_q.push_back(pat[8*j +: 8]);
              3: begin
                pre = $urandom_range(1, plen_e);
                for (int j = 0; j < pre; j++) text_q.push_back(pat[8*j +: 8]);
              end
              4:       text_q.push_back($urandom_range(0, 1) ? alpha0 : alpha1);
              default: text_q.push_back(byte_t'($urandom));
            endcase
          end
        end
        if ($urandom_range(0, 3) == 0) tx_eager = !tx_eager;
        foreach (text_q[j]) send_byte(text_q[j], j == text_q.size() - 1, 1'b0, '0);
        rand_items += text_q.size();
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d input bytes in %0d strings under %0d random register settings",
             n_items, n_strings, n_phases);
    $display("plus the directed table; %0d results compared, %0d mismatches",
             n_results, n_err);
    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
